// ===== design/assert_macros.svh =====
// assertion macros shared by the encoder modules
// each macro expects clk and arst_n in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define BZP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked in the cycle after the condition
`define BZP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== design/bzp_pkg.sv =====
// types and constants of the bipolar zero-pair line encoder
// used by bzp_ctrl, bzp_dp and the top level; depends on nothing
package bzp_pkg;

	localparam logic [7:0] ONE_CHAR = 8'd49;

	localparam logic [11:0] DAC_NEG  = 12'h000;
	localparam logic [11:0] DAC_ZERO = 12'h800;
	localparam logic [11:0] DAC_POS  = 12'hFFF;

	localparam logic signed [1:0] SYM_NEG  = 2'sb11;
	localparam logic signed [1:0] SYM_ZERO = 2'sb00;
	localparam logic signed [1:0] SYM_POS  = 2'sb01;

	localparam logic [15:0] PAYLOAD_BITS_RST = 16'd40;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BIT,
		S_SECOND,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic set_zp;
		logic clr_zp;
		logic flip;
		logic emit;
		logic lvl_zero;
		logic emit_fe;
		logic adv;
		logic frame_rst;
	} cmd_t;

	typedef struct packed {
		logic cur_bit;
		logic zp;
		logic in_prefix;
		logic hit;
		logic out_free;
	} status_t;

endpackage

// ===== design/bzp_ctrl.sv =====
// controller of the line encoder: walks the bits of one word and issues datapath commands
// depends on bzp_pkg and assert_macros.svh
`include "assert_macros.svh"

module bzp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             cfg_ready,
	input  bzp_pkg::status_t st,
	output bzp_pkg::cmd_t    cmd
);
	import bzp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_BIT;
				end
			end
			S_BIT: begin
				if (!st.zp && !st.cur_bit) begin
					if (st.in_prefix) begin
						state_d = S_BIT;
					end else if (st.hit) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_IDLE;
					end
				end else if (st.out_free) begin
					if (st.zp) begin
						state_d = S_SECOND;
					end else if (st.in_prefix) begin
						state_d = S_BIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_SECOND: begin
				if (st.out_free) begin
					state_d = st.in_prefix ? S_BIT : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				// no register write in the cycle a word is taken
				cfg_ready = !in_valid;
				cmd.load  = in_valid;
			end
			S_BIT: begin
				if (!st.zp && !st.cur_bit) begin
					// lone zero so far, hold it until the next bit
					cmd.set_zp = 1'b1;
					cmd.adv    = 1'b1;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.zp) begin
						cmd.clr_zp = 1'b1;
						// zero pair flips now, zero then one gives a level 0 first
						cmd.lvl_zero = st.cur_bit;
						cmd.flip     = !st.cur_bit;
					end else begin
						cmd.flip      = 1'b1;
						cmd.adv       = 1'b1;
						cmd.emit_fe   = !st.in_prefix && st.hit;
						cmd.frame_rst = !st.in_prefix && st.hit;
					end
				end
			end
			S_SECOND: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.flip      = st.cur_bit;
					cmd.adv       = 1'b1;
					cmd.emit_fe   = !st.in_prefix && st.hit;
					cmd.frame_rst = !st.in_prefix && st.hit;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.lvl_zero  = 1'b1;
					cmd.clr_zp    = 1'b1;
					cmd.emit_fe   = 1'b1;
					cmd.frame_rst = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`BZP_ASSERT(a_flush_has_zero, (state_q == S_FLUSH) |-> st.zp, "flush without a held zero")
	`BZP_ASSERT(a_second_no_zero, (state_q == S_SECOND) |-> !st.zp, "held zero during second symbol")
	`BZP_ASSERT(a_idle_no_prefix, (state_q == S_IDLE) |-> !st.in_prefix, "prefix left unfinished")

endmodule

// ===== design/bzp_dp.sv =====
// datapath of the line encoder: length register, line state, prefix counter, output register
// depends on bzp_pkg and assert_macros.svh
`include "assert_macros.svh"

module bzp_dp #(
	parameter int HEADER_BITS = 8,
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             bit_char,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [15:0]            cfg_data,
	input  bzp_pkg::cmd_t          cmd,
	output bzp_pkg::status_t       st,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic signed [1:0]      symbol,
	output logic [11:0]            dac_code,
	output logic                   frame_end
);
	import bzp_pkg::*;

	localparam int PREFIX_BITS = HEADER_BITS + LENGTH_BITS;
	localparam int IW          = $clog2(PREFIX_BITS);

	logic [15:0]   payload_bits_q;
	logic          pol_q;
	logic          zp_q;
	logic [15:0]   count_q;
	logic          prefix_sent_q;
	logic          in_prefix_q;
	logic [IW-1:0] idx_q;
	logic          bit_q;
	logic          hit_q;

	logic          out_valid_q;
	logic signed [1:0] symbol_q;
	logic [11:0]   dac_q;
	logic          fe_q;

	logic [15:0]   count_inc;
	logic [IW-1:0] pos;
	logic [3:0]    len_pos;
	logic          prefix_bit;
	logic          last_prefix;
	logic          pol_next;
	logic          out_free;

	assign count_inc   = count_q + 16'd1;
	// length field goes out msb first
	assign pos         = IW'(PREFIX_BITS - 1) - idx_q;
	assign len_pos     = 4'(pos);
	assign prefix_bit  = (idx_q < IW'(HEADER_BITS)) ? 1'b1 : payload_bits_q[len_pos];
	assign last_prefix = (idx_q == IW'(PREFIX_BITS - 1));
	assign pol_next    = cmd.flip ? !pol_q : pol_q;
	assign out_free    = !out_valid_q || !out_stall;

	assign st.cur_bit   = in_prefix_q ? prefix_bit : bit_q;
	assign st.zp        = zp_q;
	assign st.in_prefix = in_prefix_q;
	assign st.hit       = hit_q;
	assign st.out_free  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_bits_q <= PAYLOAD_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			payload_bits_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q         <= 1'b0;
			zp_q          <= 1'b0;
			count_q       <= '0;
			prefix_sent_q <= 1'b0;
			in_prefix_q   <= 1'b0;
			idx_q         <= '0;
			bit_q         <= 1'b0;
			hit_q         <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_q <= (bit_char == ONE_CHAR);
				hit_q <= (count_inc == payload_bits_q);
				if (!prefix_sent_q) begin
					in_prefix_q <= 1'b1;
					idx_q       <= '0;
				end
			end
			if (cmd.adv && in_prefix_q) begin
				if (last_prefix) begin
					in_prefix_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			// frame end puts the line state back to its start values
			if (cmd.frame_rst) begin
				pol_q         <= 1'b0;
				zp_q          <= 1'b0;
				count_q       <= '0;
				prefix_sent_q <= 1'b0;
			end else begin
				if (cmd.load) begin
					count_q       <= count_inc;
					prefix_sent_q <= 1'b1;
				end
				if (cmd.set_zp) begin
					zp_q <= 1'b1;
				end else if (cmd.clr_zp) begin
					zp_q <= 1'b0;
				end
				pol_q <= pol_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fe_q <= cmd.emit_fe;
			if (cmd.lvl_zero) begin
				symbol_q <= SYM_ZERO;
				dac_q    <= DAC_ZERO;
			end else if (pol_next) begin
				symbol_q <= SYM_POS;
				dac_q    <= DAC_POS;
			end else begin
				symbol_q <= SYM_NEG;
				dac_q    <= DAC_NEG;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign dac_code  = dac_q;
	assign frame_end = fe_q;

	`BZP_ASSERT(a_emit_free, cmd.emit |-> out_free, "word written over a waiting word")
	`BZP_ASSERT(a_rst_with_fe, cmd.frame_rst |-> (cmd.emit && cmd.emit_fe),
		"frame closed without a frame end word")
	`BZP_ASSERT_NEXT(a_frame_clean, cmd.frame_rst,
		(!pol_q && !zp_q && (count_q == 16'd0) && !prefix_sent_q), "line state not cleared")

endmodule

// ===== design/bipolar_zero_pair_line_encoder.sv =====
// channel   direction  handshake             word
// input     in         in_valid / in_stall    bit_char
// output    out        out_valid / out_stall  symbol, dac_code, frame_end
// config    in         cfg_valid / cfg_ready  cfg_data (payload_bits)
//
// a payload word is accepted in S_IDLE, then handled in S_BIT, and in S_SECOND after a held zero
// the first word of a frame first runs HEADER_BITS + LENGTH_BITS prefix bits
// a last word ending on a held zero goes through S_FLUSH for the level 0 symbol
// reset: payload_bits 40, polarity negative, no held zero, new frame
// out_stall holds the output register and the sequencer waits on it; in_stall is low only when idle
// cfg_ready is high only when idle with no input word offered
//
// top level of the bipolar zero-pair line encoder; depends on bzp_pkg, bzp_ctrl, bzp_dp

module bipolar_zero_pair_line_encoder #(
	parameter int HEADER_BITS = 8,
	parameter int LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        bit_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [1:0] symbol,
	output logic [11:0]       dac_code,
	output logic              frame_end,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);
	import bzp_pkg::*;

	cmd_t    cmd;
	status_t st;

	bzp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bzp_dp #(
		.HEADER_BITS (HEADER_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.bit_char  (bit_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.symbol    (symbol),
		.dac_code  (dac_code),
		.frame_end (frame_end)
	);

endmodule

// ===== tb/tb_bipolar_zero_pair_line_encoder.sv =====
// self-checking testbench for bipolar_zero_pair_line_encoder
// predicts every line symbol of a frame (ones header, length field, payload) and checks it
// depends on bzp_pkg and the encoder top level only
module tb_bipolar_zero_pair_line_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import bzp_pkg::*;

	localparam int HDR_ONES = 8;
	localparam int LEN_FIELD_BITS = 16;
	localparam int TOTAL_ITEMS = 480;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] CH_ZERO = 8'd48;

	typedef struct packed {
		logic signed [1:0] symbol;
		logic [11:0]       dac_code;
		logic              frame_end;
	} line_sym_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] bit_char = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [1:0] symbol;
	logic [11:0] dac_code;
	logic frame_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	bipolar_zero_pair_line_encoder #(
		.HEADER_BITS(HDR_ONES),
		.LENGTH_BITS(LEN_FIELD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bit_char(bit_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol(symbol),
		.dac_code(dac_code),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// encoder state as predicted
	logic [15:0] len_cfg = PAYLOAD_BITS_RST;
	logic pol_pos = 1'b0;
	logic zero_held = 1'b0;
	logic [15:0] bit_count = 16'd0;
	logic prefix_done = 1'b0;
	int step_syms;

	line_sym_t sym_q[$];
	logic [7:0] char_q[$];

	int err_count = 0;
	int items_sent = 0;
	int in_gap = 0;
	int out_hold = 0;
	int idle_cycles = 0;
	bit in_calm = 1'b1;
	bit out_calm = 1'b1;

	function automatic void push_level(int lvl);
		line_sym_t s;
		if (lvl > 0) begin
			s.symbol = SYM_POS;
			s.dac_code = DAC_POS;
		end else if (lvl < 0) begin
			s.symbol = SYM_NEG;
			s.dac_code = DAC_NEG;
		end else begin
			s.symbol = SYM_ZERO;
			s.dac_code = DAC_ZERO;
		end
		s.frame_end = 1'b0;
		sym_q.push_back(s);
		step_syms++;
	endfunction

	function automatic int flip_pol();
		pol_pos = !pol_pos;
		return pol_pos ? 1 : -1;
	endfunction

	function automatic void line_bit(logic one);
		int lvl;
		if (zero_held) begin
			zero_held = 1'b0;
			if (!one) begin
				// zero pair: one flip, two pulses of the new polarity
				lvl = flip_pol();
				push_level(lvl);
				push_level(lvl);
				return;
			end
			push_level(0);
		end
		if (one)
			push_level(flip_pol());
		else
			zero_held = 1'b1;
	endfunction

	function automatic void encode_char(logic [7:0] c);
		step_syms = 0;
		if (!prefix_done) begin
			for (int i = 0; i < HDR_ONES; i++)
				line_bit(1'b1);
			for (int i = LEN_FIELD_BITS - 1; i >= 0; i--)
				line_bit(len_cfg[i]);
			prefix_done = 1'b1;
		end
		line_bit(c == ONE_CHAR);
		bit_count = bit_count + 16'd1;
		if (bit_count == len_cfg) begin
			if (zero_held) begin
				zero_held = 1'b0;
				push_level(0);
			end
			if (step_syms > 0)
				sym_q[sym_q.size() - 1].frame_end = 1'b1;
			pol_pos = 1'b0;
			bit_count = 16'd0;
			prefix_done = 1'b0;
		end
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] rand_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return ONE_CHAR;
		else if (r < 75)
			return CH_ZERO;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic void check_symbol();
		line_sym_t want;
		if (sym_q.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("unexpected symbol %0d dac %h frame_end %b", symbol, dac_code, frame_end);
			return;
		end
		want = sym_q.pop_front();
		if (symbol !== want.symbol || dac_code !== want.dac_code
				|| frame_end !== want.frame_end) begin
			err_count++;
			if (err_count <= 10)
				$display("mismatch: expected symbol %0d dac %h frame_end %b, got %0d %h %b",
					want.symbol, want.dac_code, want.frame_end, symbol, dac_code, frame_end);
		end
	endfunction

	// driver: one word per handshake, random gaps between words
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			encode_char(bit_char);
		if (!in_valid || !in_stall) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (char_q.size() != 0) begin
				in_valid <= 1'b1;
				bit_char <= char_q.pop_front();
				in_gap <= in_calm ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_symbol();
		if (out_hold != 0) begin
			out_stall <= 1'b1;
			out_hold <= out_hold - 1;
		end else begin
			out_stall <= 1'b0;
			if (!out_calm && $urandom_range(0, 3) == 0)
				out_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_bipolar_zero_pair_line_encoder: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send(input logic [7:0] c);
		char_q.push_back(c);
		items_sent++;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send(rand_char());
	endtask

	// all words taken, all symbols seen, then a settle wait for a held zero
	task automatic wait_idle();
		@(negedge clk);
		while (char_q.size() != 0 || in_valid || sym_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_length(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		len_cfg = value;
		@(negedge clk);
	endtask

	// finish an open frame by moving the length just past the count
	task automatic close_frame();
		logic [15:0] target;
		wait_idle();
		if (bit_count != 0) begin
			if ($urandom_range(0, 1) == 1) begin
				// length at or below the count: frame must run on
				write_length(16'($urandom_range(1, bit_count)));
				send_random(1);
				wait_idle();
			end
			target = bit_count + 16'($urandom_range(1, 4));
			write_length(target);
			send_random(target - bit_count);
		end
	endtask

	initial begin
		int phase;
		int unsigned pick;
		logic [15:0] len;
		int count;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset length of 40, then moved mid-frame above the count
		send(ONE_CHAR);
		send(CH_ZERO);
		send(8'd0);
		send(ONE_CHAR);
		send(CH_ZERO);
		wait_idle();
		write_length(16'd7);
		send(8'd255);
		send(CH_ZERO);

		// one-bit frames: a one, and zeros flushed as level 0
		wait_idle();
		write_length(16'd1);
		send(ONE_CHAR);
		send(CH_ZERO);
		send(8'd0);
		send(8'd255);
		send(8'd177);

		// two-bit frames: every pair
		wait_idle();
		in_calm = 1'b0;
		out_calm = 1'b0;
		write_length(16'd2);
		send(CH_ZERO);
		send(CH_ZERO);
		send(CH_ZERO);
		send(ONE_CHAR);
		send(ONE_CHAR);
		send(CH_ZERO);
		send(ONE_CHAR);
		send(ONE_CHAR);

		// length dropped below the count mid-frame, then raised to end it
		wait_idle();
		write_length(16'd5);
		send(CH_ZERO);
		send(ONE_CHAR);
		send(CH_ZERO);
		wait_idle();
		write_length(16'd2);
		send(CH_ZERO);
		wait_idle();
		write_length(16'd6);
		send(CH_ZERO);
		send(CH_ZERO);

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			wait_idle();
			in_calm = ($urandom_range(0, 4) == 0);
			out_calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (phase == 0)
				len = 16'hFFFF;
			else if (phase == 1)
				len = 16'h0000;
			else if (pick < 3)
				len = 16'($urandom_range(13, 60));
			else
				len = 16'($urandom_range(1, 12));
			write_length(len);
			if (len == 16'hFFFF || len == 16'h0000)
				count = $urandom_range(20, 50);
			else if (len > 16'd12)
				count = len;
			else
				count = len * $urandom_range(1, 4);
			if (len <= 16'd60 && len != 16'd0 && $urandom_range(0, 3) == 0)
				count += $urandom_range(1, len);
			send_random(count);
			close_frame();
			phase++;
		end

		wait_idle();
		if (err_count == 0)
			$display("tb_bipolar_zero_pair_line_encoder: PASS");
		else
			$display("tb_bipolar_zero_pair_line_encoder: FAIL");
		$finish;
	end

endmodule
